@@ sv/weighted_graph_edge_store_macros.svh @@
// assertion helpers used by the checker file
// each macro samples on clk_i and is disabled while rst_ni is low
`ifndef WEIGHTED_GRAPH_EDGE_STORE_MACROS_SVH
`define WEIGHTED_GRAPH_EDGE_STORE_MACROS_SVH

// same-cycle implication
`define WGES_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define WGES_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/wges_pkg.sv @@
`default_nettype none

package wges_pkg;

  localparam int unsigned IdW     = 6;
  localparam int unsigned WeightW = 16;

  typedef enum logic [2:0] {
    REQ_ADD        = 3'd0,
    REQ_REMOVE     = 3'd1,
    REQ_CONNECT    = 3'd2,
    REQ_DISCONNECT = 3'd3,
    REQ_QUERY      = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CHANGE = 2'd1,
    ST_ABSENT    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_WR_A,
    S_WR_B,
    S_RD,
    S_CHK,
    S_QUERY,
    S_STATUS
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [IdW-1:0]     node_a;
    logic [IdW-1:0]     node_b;
    logic [WeightW-1:0] weight_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_neighbor;
    logic [IdW-1:0]     neighbor_id;
    logic [WeightW-1:0] neighbor_weight;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

@@ sv/weighted_graph_edge_store.sv @@
// Weighted undirected graph store over node ids 0..min(MAX_NODES,64)-1; larger ids count
// as absent. Edges live in one synchronous edge memory (one write port, one read port,
// registered read) holding a present bit and a WEIGHT_BITS weight per ordered node pair;
// node presence is a flip-flop vector cleared by reset. The block works on one request
// at a time and takes the next once the current one has handed its last word to the
// output register. add_node and remove_node walk the node's row and column through the
// single write port. connect writes both entries of the pair; disconnect reads, checks,
// then writes both entries, or stops after the check when there is no edge. query
// streams the node's row, one entry per cycle while the output is not held. Rejected
// requests, clear and unused codes go straight to the status word. Entries are cleared
// when a node is added, so no clearing pass runs after reset.
`default_nettype none

module weighted_graph_edge_store #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  wges_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output wges_pkg::rsp_t rsp_o
);

  import wges_pkg::*;

  localparam int unsigned NumNodes = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int unsigned IdxW     = $clog2(NumNodes);
  localparam int unsigned IdxDepth = 1 << IdxW;
  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned EntryW   = WEIGHT_BITS + 1;
  localparam int unsigned CntW     = IdxW + 1;

  // edge memory: {present, weight}, row = first node, column = second node
  logic [EntryW-1:0] edge_mem [MemDepth];
  logic [EntryW-1:0] rd_data_q;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;

  state_e               state_q, state_d;
  logic [2:0]           op_q, op_d;
  logic [IdxW-1:0]      a_q, a_d, b_q, b_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  status_e              status_q, status_d;
  logic [IdxDepth-1:0]  node_pres_q, node_pres_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      kr_q, kr_d;
  logic                 v1_q, v1_d;
  logic [IdxW-1:0]      k1_q, k1_d;
  logic                 pend_v_q, pend_v_d;
  logic [IdxW-1:0]      pend_id_q, pend_id_d;
  logic [WEIGHT_BITS-1:0] pend_w_q, pend_w_d;
  logic                 out_v_q, out_v_d;
  rsp_t                 out_q, out_d;

  logic            accept;
  logic [IdxW-1:0] a_idx, b_idx;
  logic            a_ok, b_ok, pres_a, pres_b;
  logic            out_free;
  logic            walk_last;
  logic [IdxW-1:0] walk_k;
  logic            rd_present;
  logic            q_hit, q_consume, q_issue, q_finish;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

  assign a_idx  = req_i.node_a[IdxW-1:0];
  assign b_idx  = req_i.node_b[IdxW-1:0];
  assign a_ok   = int'(req_i.node_a) < NumNodes;
  assign b_ok   = int'(req_i.node_b) < NumNodes;
  assign pres_a = a_ok && node_pres_q[a_idx];
  assign pres_b = b_ok && node_pres_q[b_idx];

  assign out_free   = !out_v_q || rsp_ready_i;
  assign walk_last  = (cnt_q == CntW'(2 * NumNodes - 1));
  assign walk_k     = cnt_q[IdxW:1];
  assign rd_present = rd_data_q[WEIGHT_BITS];

  // query row stream: one read in flight, a held candidate decides the last flag
  assign q_hit     = v1_q && rd_present && (rd_data_q[WEIGHT_BITS-1:0] >= w_q);
  assign q_consume = v1_q && (!q_hit || !pend_v_q || out_free);
  assign q_issue   = (!v1_q || q_consume) && (kr_q < CntW'(NumNodes));
  assign q_finish  = (kr_q == CntW'(NumNodes)) && !v1_q && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_ADD:        state_d = (!a_ok || pres_a) ? S_STATUS : S_WALK;
            REQ_REMOVE:     state_d = pres_a ? S_WALK : S_STATUS;
            REQ_CONNECT:    state_d = (pres_a && pres_b) ? S_WR_A : S_STATUS;
            REQ_DISCONNECT: state_d = (pres_a && pres_b) ? S_RD : S_STATUS;
            REQ_QUERY:      state_d = pres_a ? S_QUERY : S_STATUS;
            default:        state_d = S_STATUS;
          endcase
        end
      end
      S_WALK:   if (walk_last) state_d = S_STATUS;
      S_WR_A:   state_d = S_WR_B;
      S_WR_B:   state_d = S_STATUS;
      S_RD:     state_d = S_CHK;
      S_CHK:    state_d = rd_present ? S_WR_A : S_STATUS;
      S_QUERY:  if (q_finish) state_d = S_IDLE;
      S_STATUS: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    w_d         = w_q;
    status_d    = status_q;
    node_pres_d = node_pres_q;
    cnt_d       = cnt_q;
    kr_d        = kr_q;
    v1_d        = v1_q;
    k1_d        = k1_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    pend_w_d    = pend_w_q;
    out_v_d     = out_v_q && !rsp_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = {a_q, b_q};
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = {a_q, b_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = req_i.req_type;
          a_d      = a_idx;
          b_d      = b_idx;
          w_d      = WEIGHT_BITS'(req_i.weight_value);
          cnt_d    = '0;
          kr_d     = '0;
          v1_d     = 1'b0;
          pend_v_d = 1'b0;
          unique case (req_i.req_type) inside
            REQ_ADD: begin
              if (!a_ok || pres_a) begin
                status_d = ST_NO_CHANGE;
              end else begin
                status_d           = ST_OK;
                node_pres_d[a_idx] = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (pres_a) begin
                status_d           = ST_OK;
                node_pres_d[a_idx] = 1'b0;
              end else begin
                status_d = ST_ABSENT;
              end
            end
            REQ_CONNECT, REQ_DISCONNECT: begin
              status_d = (pres_a && pres_b) ? ST_OK : ST_ABSENT;
            end
            REQ_QUERY: status_d = pres_a ? ST_OK : ST_ABSENT;
            REQ_CLEAR: begin
              status_d    = ST_OK;
              node_pres_d = '0;
            end
            default: status_d = ST_NO_CHANGE;
          endcase
        end
      end
      S_WALK: begin
        // even steps clear the row entry, odd steps the column entry
        mem_we    = 1'b1;
        mem_waddr = cnt_q[0] ? {walk_k, a_q} : {a_q, walk_k};
        cnt_d     = cnt_q + 1'b1;
      end
      S_WR_A, S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = (state_q == S_WR_A) ? {a_q, b_q} : {b_q, a_q};
        mem_wdata = (op_q == REQ_CONNECT) ? {1'b1, w_q} : '0;
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_CHK: begin
        status_d = rd_present ? ST_OK : ST_NO_CHANGE;
      end
      S_QUERY: begin
        if (q_consume && q_hit) begin
          if (pend_v_q) begin
            out_v_d               = 1'b1;
            out_d.status          = ST_OK;
            out_d.has_neighbor    = 1'b1;
            out_d.neighbor_id     = IdW'(pend_id_q);
            out_d.neighbor_weight = WeightW'(pend_w_q);
            out_d.last            = 1'b0;
          end
          pend_v_d  = 1'b1;
          pend_id_d = k1_q;
          pend_w_d  = rd_data_q[WEIGHT_BITS-1:0];
        end
        if (q_issue) begin
          mem_re    = 1'b1;
          mem_raddr = {a_q, kr_q[IdxW-1:0]};
          kr_d      = kr_q + 1'b1;
          k1_d      = kr_q[IdxW-1:0];
          v1_d      = 1'b1;
        end else if (q_consume) begin
          v1_d = 1'b0;
        end
        if (q_finish) begin
          // held candidate closes the list, or an empty result if none qualified
          out_v_d               = 1'b1;
          out_d.status          = ST_OK;
          out_d.has_neighbor    = pend_v_q;
          out_d.neighbor_id     = pend_v_q ? IdW'(pend_id_q) : '0;
          out_d.neighbor_weight = pend_v_q ? WeightW'(pend_w_q) : '0;
          out_d.last            = 1'b1;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_v_d               = 1'b1;
          out_d.status          = status_q;
          out_d.has_neighbor    = 1'b0;
          out_d.neighbor_id     = '0;
          out_d.neighbor_weight = '0;
          out_d.last            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      edge_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= edge_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      node_pres_q <= '0;
      out_v_q     <= 1'b0;
      v1_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      kr_q        <= '0;
    end else begin
      state_q     <= state_d;
      node_pres_q <= node_pres_d;
      out_v_q     <= out_v_d;
      v1_q        <= v1_d;
      pend_v_q    <= pend_v_d;
      cnt_q       <= cnt_d;
      kr_q        <= kr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    w_q       <= w_d;
    status_q  <= status_d;
    k1_q      <= k1_d;
    pend_id_q <= pend_id_d;
    pend_w_q  <= pend_w_d;
    out_q     <= out_d;
  end

endmodule

`default_nettype wire

@@ sv/wges_checker.sv @@
`default_nettype none

`include "weighted_graph_edge_store_macros.svh"

module wges_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input wges_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input wges_pkg::rsp_t rsp_o
);

  import wges_pkg::*;

  logic nbr_zero;

  assign nbr_zero = (rsp_o.neighbor_id == '0) && (rsp_o.neighbor_weight == '0);

  // a held word keeps its valid and its contents
  `WGES_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && !rsp_ready_i, rsp_valid_o && $stable(rsp_o))

  // words without a neighbor carry zero id and weight
  `WGES_ASSERT_IMP(a_empty_zero, rsp_valid_o && !rsp_o.has_neighbor, nbr_zero)

  // neighbor words only come from a query of a present node
  `WGES_ASSERT_IMP(a_nbr_ok, rsp_valid_o && rsp_o.has_neighbor, rsp_o.status == ST_OK)

  // one request at a time: the input closes right after a word is taken
  `WGES_ASSERT_NEXT(a_one_req, req_valid_i && req_ready_o, !req_ready_o)

endmodule

bind weighted_graph_edge_store wges_checker u_wges_checker (.*);

`default_nettype wire
